@@ rtl/core/mpdsc_pkg.sv @@
`timescale 1ns / 1ps

package mpdsc_pkg;

    localparam int TYPE_LIMIT_DEFAULT = 15;
    localparam int HDR_BYTES          = 8;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [7:0] HEAD_BYTE = 8'h7F;
    localparam logic [7:0] TAIL_BYTE = 8'hFF;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_TAIL    = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_NEXT    = 2'd1,
        EV_DONE    = 2'd2,
        EV_FAIL    = 2'd3
    } event_kind_t;

    // one classified byte handed from the front to the back
    typedef struct packed {
        logic        is_tail;
        logic        self_err;
        logic [7:0]  data;
        logic [7:0]  ptype;
        logic [15:0] id;
        logic [15:0] total;
    } queue_entry_t;

endpackage

@@ rtl/core/mpdsc_front.sv @@
`timescale 1ns / 1ps

module mpdsc_front #(
    parameter int TYPE_LIMIT = mpdsc_pkg::TYPE_LIMIT_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [7:0]              s_rx_byte,
    input  logic                    s_valid,
    output logic                    s_ready,
    output logic                    push,
    output mpdsc_pkg::queue_entry_t push_data,
    input  logic                    full
);
    import mpdsc_pkg::*;

    localparam logic [7:0] TypeLimit = 8'(TYPE_LIMIT);

    phase_t      phase_reg, phase_next;
    logic [2:0]  hidx_reg, hidx_next;
    logic [15:0] remain_reg, remain_next;
    logic [7:0]  hdr_reg [HDR_BYTES];

    logic        accept;
    logic [15:0] datalen;
    logic [7:0]  head;
    logic [7:0]  ptype;
    logic [15:0] cur_id;
    logic [15:0] tot_word;
    logic        self_err;

    assign s_ready  = !full;
    assign accept   = s_valid && s_ready;

    assign head     = hdr_reg[0];
    assign ptype    = hdr_reg[1];
    assign cur_id   = {hdr_reg[3], hdr_reg[2]};
    assign tot_word = {hdr_reg[5], hdr_reg[4]};
    assign datalen  = {s_rx_byte, hdr_reg[6]};

    assign self_err = (head != HEAD_BYTE) || (ptype == 8'd0) || (ptype >= TypeLimit) ||
                      (cur_id > tot_word) || (tot_word == 16'd0) || (s_rx_byte != TAIL_BYTE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            hidx_reg   <= 3'd0;
            remain_reg <= 16'd0;
        end else begin
            phase_reg  <= phase_next;
            hidx_reg   <= hidx_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && phase_reg == PH_HEADER) begin
            hdr_reg[hidx_reg] <= s_rx_byte;
        end
    end

    always_comb begin
        phase_next         = phase_reg;
        hidx_next          = hidx_reg;
        remain_next        = remain_reg;
        push               = 1'b0;
        push_data.is_tail  = (phase_reg == PH_TAIL);
        push_data.self_err = self_err;
        push_data.data     = (phase_reg == PH_TAIL) ? 8'd0 : s_rx_byte;
        push_data.ptype    = ptype;
        push_data.id       = cur_id;
        push_data.total    = tot_word;
        unique case (phase_reg)
            PH_HEADER: begin
                if (accept) begin
                    hidx_next = hidx_reg + 3'd1;
                    if (hidx_reg == 3'(HDR_BYTES - 1)) begin
                        remain_next = datalen;
                        phase_next  = (datalen == 16'd0) ? PH_TAIL : PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (accept) begin
                    push        = 1'b1;
                    remain_next = remain_reg - 16'd1;
                    if (remain_reg == 16'd1) begin
                        phase_next = PH_TAIL;
                    end
                end
            end
            PH_TAIL: begin
                if (accept) begin
                    push        = 1'b1;
                    hidx_next   = 3'd0;
                    remain_next = 16'd0;
                    phase_next  = PH_HEADER;
                end
            end
            default: begin
                phase_next = PH_HEADER;
            end
        endcase
    end

    a_payload_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> remain_reg != 16'd0)
        else $error("payload phase with nothing left to count");

    a_header_idle_index: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_HEADER |-> hidx_reg == 3'd0)
        else $error("header index not rewound outside header phase");

endmodule

@@ rtl/core/mpdsc_queue.sv @@
`timescale 1ns / 1ps

module mpdsc_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  mpdsc_pkg::queue_entry_t push_data,
    output logic                    full,
    input  logic                    pop,
    output mpdsc_pkg::queue_entry_t pop_data,
    output logic                    empty
);
    import mpdsc_pkg::*;

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    queue_entry_t    mem_reg [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full     = (count_reg == CntW'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CntW'(push) - CntW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("write into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("read from empty queue");

endmodule

@@ rtl/core/mpdsc_back.sv @@
`timescale 1ns / 1ps

module mpdsc_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  mpdsc_pkg::queue_entry_t pop_data,
    input  logic                    empty,
    output logic                    pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_event_kind,
    output logic [7:0]              m_payload_byte,
    output logic [7:0]              m_packet_type,
    output logic [15:0]             m_packet_id,
    output logic [15:0]             m_packet_total
);
    import mpdsc_pkg::*;

    logic [15:0] exp_reg, exp_next;
    logic [15:0] ttot_reg, ttot_next;
    logic [7:0]  ttype_reg, ttype_next;
    logic        m_valid_reg, m_valid_next;

    event_kind_t ev_reg;
    logic [7:0]  byte_reg;
    logic [7:0]  type_reg;
    logic [15:0] id_reg;
    logic [15:0] total_reg;

    logic        take;
    logic        first;
    logic [15:0] eff_total;
    logic [7:0]  eff_type;
    event_kind_t ev;

    assign take      = !empty && (!m_valid_reg || m_ready);
    assign pop       = take;
    assign first     = (exp_reg == 16'd1);
    // the first packet of a transfer sets the reference total and type
    assign eff_total = first ? pop_data.total : ttot_reg;
    assign eff_type  = first ? pop_data.ptype : ttype_reg;

    always_comb begin
        priority if (!pop_data.is_tail) begin
            ev = EV_PAYLOAD;
        end else if (pop_data.self_err) begin
            ev = EV_FAIL;
        end else if (pop_data.id != exp_reg || pop_data.ptype != eff_type ||
                     pop_data.total != eff_total) begin
            ev = EV_FAIL;
        end else if (pop_data.id == eff_total) begin
            ev = EV_DONE;
        end else begin
            ev = EV_NEXT;
        end
    end

    always_comb begin
        exp_next   = exp_reg;
        ttot_next  = ttot_reg;
        ttype_next = ttype_reg;
        if (take && pop_data.is_tail) begin
            if (ev == EV_NEXT) begin
                exp_next   = exp_reg + 16'd1;
                ttot_next  = eff_total;
                ttype_next = eff_type;
            end else begin
                exp_next   = 16'd1;
                ttot_next  = 16'd0;
                ttype_next = 8'd0;
            end
        end
        if (take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_reg     <= 16'd1;
            ttot_reg    <= 16'd0;
            ttype_reg   <= 8'd0;
            m_valid_reg <= 1'b0;
        end else begin
            exp_reg     <= exp_next;
            ttot_reg    <= ttot_next;
            ttype_reg   <= ttype_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            ev_reg    <= ev;
            byte_reg  <= pop_data.data;
            type_reg  <= pop_data.ptype;
            id_reg    <= pop_data.id;
            total_reg <= pop_data.total;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_event_kind   = ev_reg;
    assign m_payload_byte = byte_reg;
    assign m_packet_type  = type_reg;
    assign m_packet_id    = id_reg;
    assign m_packet_total = total_reg;

    a_expected_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        exp_reg != 16'd0)
        else $error("expected id reached zero");

    a_clear_after_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        take && pop_data.is_tail && (ev == EV_DONE || ev == EV_FAIL)
        |=> exp_reg == 16'd1 && ttot_reg == 16'd0 && ttype_reg == 8'd0)
        else $error("transfer state not cleared after final verdict");

endmodule

@@ rtl/core/multi_packet_deframe_sequence_check.sv @@
`timescale 1ns / 1ps

// packet stream deframer with id sequence check
// input channel (s_valid/s_ready/s_rx_byte): one received byte per transaction;
// packets are a 7f head, type, cur_id, total_id, datalen (little endian), payload
// and an ff tail byte
// result channel (m_valid/m_ready/m_*): one transaction per payload byte, one
// verdict per tail byte (next packet, transfer done, or fail); header bytes
// give no result
// the front stage tracks the framing and runs the per-packet checks, a
// two-entry queue feeds the back stage, which does the sequence check and
// holds the output register
// each result is written into the queue, then registered in the output register before it is offered
// throughput: one byte per cycle while the queue is not full, limited by the single-byte input port
// when the receiver stalls, the output register and both queue entries fill,
// then s_ready drops (header bytes are held too while the queue is full);
// nothing is dropped
// reset (aresetn low, synchronous) returns to header phase, empties the queue
// and restarts the transfer expecting id 1
module multi_packet_deframe_sequence_check #(
    parameter int TYPE_LIMIT = mpdsc_pkg::TYPE_LIMIT_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_kind,
    output logic [7:0]  m_payload_byte,
    output logic [7:0]  m_packet_type,
    output logic [15:0] m_packet_id,
    output logic [15:0] m_packet_total
);
    import mpdsc_pkg::*;

    queue_entry_t push_data;
    queue_entry_t pop_data;
    logic         push;
    logic         pop;
    logic         full;
    logic         empty;

    mpdsc_front #(
        .TYPE_LIMIT(TYPE_LIMIT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_rx_byte (s_rx_byte),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    mpdsc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    mpdsc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pop_data       (pop_data),
        .empty          (empty),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_payload_byte (m_payload_byte),
        .m_packet_type  (m_packet_type),
        .m_packet_id    (m_packet_id),
        .m_packet_total (m_packet_total)
    );

endmodule
